@@ src/ucd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and command/status types for the Unix seconds to
// calendar date converter. No dependencies.
package ucd_pkg;

	localparam int unsigned SecsPerDay  = 24 * 60 * 60;
	localparam int unsigned SecsPerHour = 3600;
	localparam int unsigned SecsPerMin  = 60;
	localparam int unsigned EpochYear   = 1970;
	localparam int unsigned EpochMod100 = EpochYear % 100;
	localparam int unsigned EpochMod400 = EpochYear % 400;
	localparam int unsigned DaysCommon  = 365;
	localparam int unsigned DaysLeap    = 366;
	localparam int unsigned LastMonth   = 11;

	// Constant divisions by reciprocal multiplication. The low zero bits of each divisor
	// are shifted off first, and each reciprocal is rounded up so that the quotient is
	// exact over the whole range of its dividend.
	localparam int unsigned DayPreShift  = 7;
	localparam int unsigned DayRecip     = 50903317;
	localparam int unsigned DayShift     = 35;
	localparam int unsigned DayProdW     = 51;
	localparam int unsigned HourPreShift = 4;
	localparam int unsigned HourRecip    = 9321;
	localparam int unsigned HourShift    = 21;
	localparam int unsigned HourProdW    = 26;
	localparam int unsigned MinPreShift  = 2;
	localparam int unsigned MinRecip     = 1093;
	localparam int unsigned MinShift     = 14;
	localparam int unsigned MinProdW     = 20;

	localparam int unsigned TsW   = 32;
	localparam int unsigned TodW  = 17;
	localparam int unsigned HremW = 12;
	localparam int unsigned DayW  = 16;

	typedef struct packed {
		logic load_ts;
		logic cal_load;
		logic tod_load;
		logic hour_load;
		logic hrem_load;
		logic min_load;
		logic year_step;
		logic month_step;
		logic publish;
	} ucd_cmd_t;

	typedef struct packed {
		logic year_fits;
		logic month_fits;
	} ucd_sts_t;

	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		case (mon)
			4'd0:    len = 5'd31;
			4'd1:    len = leap ? 5'd29 : 5'd28;
			4'd2:    len = 5'd31;
			4'd3:    len = 5'd30;
			4'd4:    len = 5'd31;
			4'd5:    len = 5'd30;
			4'd6:    len = 5'd31;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd30;
			4'd9:    len = 5'd31;
			4'd10:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

@@ src/ucd_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: reciprocal-multiply splits, year/month stepping and result registers.
// Depends on ucd_pkg for constants, command and status types.
module ucd_datapath (
	input  logic              clk,
	input  ucd_pkg::ucd_cmd_t cmd,
	output ucd_pkg::ucd_sts_t sts,
	input  logic [31:0]       unix_seconds,
	output logic [11:0]       year,
	output logic [3:0]        month,
	output logic [4:0]        day,
	output logic [4:0]        hour,
	output logic [5:0]        minute,
	output logic [5:0]        second
);

	logic [ucd_pkg::TsW-1:0]       ts_q;
	logic [ucd_pkg::TodW-1:0]      tod_q;
	logic [4:0]                    hour_q;
	logic [ucd_pkg::HremW-1:0]     hrem_q;
	logic [5:0]                    minute_q;

	logic [ucd_pkg::DayProdW-1:0]  day_prod;
	logic [ucd_pkg::TsW-1:0]       day_base;
	logic [ucd_pkg::TsW-1:0]       tod_full;
	logic [ucd_pkg::HourProdW-1:0] hour_prod;
	logic [ucd_pkg::TodW-1:0]      hour_base;
	logic [ucd_pkg::TodW-1:0]      hrem_full;
	logic [ucd_pkg::MinProdW-1:0]  min_prod;
	logic [ucd_pkg::HremW-1:0]     min_base;
	logic [ucd_pkg::HremW-1:0]     sec_full;

	logic [ucd_pkg::DayW-1:0] days_q;
	logic [11:0]              year_q;
	logic [6:0]               m100_q;
	logic [8:0]               m400_q;
	logic [3:0]               mon_q;
	logic                     leap;
	logic [8:0]               ylen;
	logic [4:0]               mlen;

	logic [11:0] year_out_q;
	logic [3:0]  month_out_q;
	logic [4:0]  day_out_q;
	logic [4:0]  hour_out_q;
	logic [5:0]  minute_out_q;
	logic [5:0]  second_out_q;

	// Whole days: 86400 is 128 times 675, so the low seven bits drop out first.
	assign day_prod = ucd_pkg::DayProdW'(ts_q[ucd_pkg::TsW-1:ucd_pkg::DayPreShift]) *
		ucd_pkg::DayProdW'(ucd_pkg::DayRecip);
	assign day_base = ucd_pkg::TsW'(days_q) * ucd_pkg::TsW'(ucd_pkg::SecsPerDay);
	assign tod_full = ts_q - day_base;

	// Hours: 3600 is 16 times 225.
	assign hour_prod = ucd_pkg::HourProdW'(tod_q[ucd_pkg::TodW-1:ucd_pkg::HourPreShift]) *
		ucd_pkg::HourProdW'(ucd_pkg::HourRecip);
	assign hour_base = ucd_pkg::TodW'(hour_q) * ucd_pkg::TodW'(ucd_pkg::SecsPerHour);
	assign hrem_full = tod_q - hour_base;

	// Minutes: 60 is 4 times 15.
	assign min_prod = ucd_pkg::MinProdW'(hrem_q[ucd_pkg::HremW-1:ucd_pkg::MinPreShift]) *
		ucd_pkg::MinProdW'(ucd_pkg::MinRecip);
	assign min_base = ucd_pkg::HremW'(minute_q) * ucd_pkg::HremW'(ucd_pkg::SecsPerMin);
	assign sec_full = hrem_q - min_base;

	// Gregorian rule from running remainders of the year, so no divider is needed.
	assign leap = (m400_q == 9'd0) || ((year_q[1:0] == 2'd0) && (m100_q != 7'd0));
	assign ylen = leap ? 9'(ucd_pkg::DaysLeap) : 9'(ucd_pkg::DaysCommon);
	assign mlen = ucd_pkg::month_len(mon_q, leap);

	assign sts.year_fits  = days_q >= ucd_pkg::DayW'(ylen);
	assign sts.month_fits = (mon_q < 4'(ucd_pkg::LastMonth)) &&
		(days_q >= ucd_pkg::DayW'(mlen));

	always_ff @(posedge clk) begin
		if (cmd.load_ts)
			ts_q <= unix_seconds;

		// The day count is still untouched here, as the walk only starts in ST_SPLIT, the state after this one.
		if (cmd.tod_load)
			tod_q <= tod_full[ucd_pkg::TodW-1:0];

		if (cmd.hour_load)
			hour_q <= hour_prod[ucd_pkg::HourShift +: 5];

		if (cmd.hrem_load)
			hrem_q <= hrem_full[ucd_pkg::HremW-1:0];

		if (cmd.min_load)
			minute_q <= min_prod[ucd_pkg::MinShift +: 6];

		if (cmd.cal_load) begin
			days_q <= day_prod[ucd_pkg::DayShift +: ucd_pkg::DayW];
			year_q <= 12'(ucd_pkg::EpochYear);
			m100_q <= 7'(ucd_pkg::EpochMod100);
			m400_q <= 9'(ucd_pkg::EpochMod400);
			mon_q  <= '0;
		end else if (cmd.year_step) begin
			days_q <= days_q - ucd_pkg::DayW'(ylen);
			year_q <= year_q + 12'd1;
			m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
			m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
		end else if (cmd.month_step) begin
			days_q <= days_q - ucd_pkg::DayW'(mlen);
			mon_q  <= mon_q + 4'd1;
		end

		if (cmd.publish) begin
			year_out_q   <= year_q;
			month_out_q  <= mon_q + 4'd1;
			day_out_q    <= days_q[4:0] + 5'd1;
			hour_out_q   <= hour_q;
			minute_out_q <= minute_q;
			second_out_q <= sec_full[5:0];
		end
	end

	assign year   = year_out_q;
	assign month  = month_out_q;
	assign day    = day_out_q;
	assign hour   = hour_out_q;
	assign minute = minute_out_q;
	assign second = second_out_q;

endmodule

@@ src/ucd_controller.sv @@
`timescale 1ns / 1ps
// Controller: sequences the day split, then the year/month walk alongside the
// hour/minute split, and hands results to the output register. Uses ucd_pkg.
module ucd_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ts_valid,
	output logic              ts_ready,
	output logic              date_valid,
	input  logic              date_ready,
	input  ucd_pkg::ucd_sts_t sts,
	output ucd_pkg::ucd_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DAY   = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_SPLIT = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [1:0] TM_HOUR = 2'd0;
	localparam logic [1:0] TM_HREM = 2'd1;
	localparam logic [1:0] TM_MIN  = 2'd2;
	localparam logic [1:0] TM_DONE = 2'd3;

	localparam logic [1:0] CA_YEAR  = 2'd0;
	localparam logic [1:0] CA_MONTH = 2'd1;
	localparam logic [1:0] CA_DONE  = 2'd2;

	logic [2:0] state_q;
	logic [1:0] tm_ph_q;
	logic [1:0] cal_ph_q;
	logic       date_valid_q;

	always_comb begin
		cmd      = '0;
		ts_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ts_ready    = 1'b1;
				cmd.load_ts = ts_valid;
			end
			ST_DAY: begin
				cmd.cal_load = 1'b1;
			end
			ST_LOAD: begin
				cmd.tod_load = 1'b1;
			end
			ST_SPLIT: begin
				case (tm_ph_q)
					TM_HOUR: cmd.hour_load = 1'b1;
					TM_HREM: cmd.hrem_load = 1'b1;
					TM_MIN:  cmd.min_load  = 1'b1;
					default: cmd.min_load  = 1'b0;
				endcase
				case (cal_ph_q)
					CA_YEAR:  cmd.year_step  = sts.year_fits;
					CA_MONTH: cmd.month_step = sts.month_fits;
					default:  cmd.year_step  = 1'b0;
				endcase
			end
			ST_OUT: begin
				cmd.publish = !date_valid_q || date_ready;
			end
			default: ts_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tm_ph_q      <= TM_HOUR;
			cal_ph_q     <= CA_YEAR;
			date_valid_q <= 1'b0;
		end else begin
			if (cmd.publish)
				date_valid_q <= 1'b1;
			else if (date_ready)
				date_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (ts_valid)
						state_q <= ST_DAY;
				end
				ST_DAY: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q  <= ST_SPLIT;
					tm_ph_q  <= TM_HOUR;
					cal_ph_q <= CA_YEAR;
				end
				ST_SPLIT: begin
					case (tm_ph_q)
						TM_HOUR: tm_ph_q <= TM_HREM;
						TM_HREM: tm_ph_q <= TM_MIN;
						default: tm_ph_q <= TM_DONE;
					endcase
					case (cal_ph_q)
						CA_YEAR:  if (!sts.year_fits) cal_ph_q <= CA_MONTH;
						CA_MONTH: if (!sts.month_fits) cal_ph_q <= CA_DONE;
						default:  cal_ph_q <= CA_DONE;
					endcase
					if (tm_ph_q == TM_DONE && cal_ph_q == CA_DONE)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (cmd.publish)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign date_valid = date_valid_q;

endmodule

@@ src/unix_seconds_to_calendar_date.sv @@
`timescale 1ns / 1ps
// Top level of the Unix seconds to UTC calendar date converter.
// Depends on ucd_pkg, ucd_controller and ucd_datapath.
//
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------
//  ts      | ts_valid / ts_ready     | unix_seconds
//  date    | date_valid / date_ready | year, month, day, hour, minute, second
//
// One timestamp is converted at a time. After the transfer in, ST_DAY takes whole days by a
// reciprocal multiply and ST_LOAD forms the seconds of the day. The year/month walk then
// steps a year or month at a time in ST_SPLIT, with the hour/minute split beside it, and
// ST_OUT loads the result register. Reset clears only the controller. A new timestamp is
// taken while the previous result waits in the output register; a stalled result holds
// back the next one.
module unix_seconds_to_calendar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ts_valid,
	output logic        ts_ready,
	input  logic [31:0] unix_seconds,
	output logic        date_valid,
	input  logic        date_ready,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	ucd_pkg::ucd_cmd_t cmd;
	ucd_pkg::ucd_sts_t sts;

	ucd_controller u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.ts_valid   (ts_valid),
		.ts_ready   (ts_ready),
		.date_valid (date_valid),
		.date_ready (date_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	ucd_datapath u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.sts          (sts),
		.unix_seconds (unix_seconds),
		.year         (year),
		.month        (month),
		.day          (day),
		.hour         (hour),
		.minute       (minute),
		.second       (second)
	);

	// A transfer in starts a conversion, so the input side must close at once.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		ts_valid && ts_ready |=> !ts_ready)
		else $error("input still ready after a transfer");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		date_valid |-> (year >= 12'd1970) && (year <= 12'd2106) &&
			(month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1))
		else $error("calendar date out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		date_valid |-> (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59))
		else $error("time of day out of range");

	// A result only appears after a conversion has been started.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(date_valid) |-> !$past(ts_ready))
		else $error("result raised while idle");

endmodule

@@ tb/unix_seconds_to_calendar_date_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for unix_seconds_to_calendar_date: directed dates, then random
// timestamps, many aimed at day and year edges, with idle bursts on both channels.
// Depends on ucd_pkg and the converter RTL.
module unix_seconds_to_calendar_date_tb;

	localparam int unsigned RandomItems = 1830;
	localparam int unsigned QuietItems  = 150;
	localparam int unsigned TailCycles  = 256;
	localparam int unsigned CycleLimit  = 2000000;
	localparam int unsigned LeapFebDays = 29;
	localparam int unsigned LastFullDay = 49709;
	localparam int unsigned LastFullYear = 2105;
	localparam logic [0:11][4:0] CommonMonthDays = {
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} cal_date_t;

	typedef struct {
		logic [31:0] ts;
		bit          known;
		cal_date_t   want;
	} date_case_t;

	logic        clk;
	logic        arst_n;
	logic        ts_valid;
	logic        ts_ready;
	logic [31:0] unix_seconds;
	logic        date_valid;
	logic        date_ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	cal_date_t   pending_dates [$];
	date_case_t  directed_cases [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	bit          quiet_tail = 1'b0;

	unix_seconds_to_calendar_date dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.ts_valid     (ts_valid),
		.ts_ready     (ts_ready),
		.unix_seconds (unix_seconds),
		.date_valid   (date_valid),
		.date_ready   (date_ready),
		.year         (year),
		.month        (month),
		.day          (day),
		.hour         (hour),
		.minute       (minute),
		.second       (second)
	);

	function automatic bit is_leap_year(input int unsigned yr);
		return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
	endfunction

	function automatic cal_date_t date_from_seconds(input logic [31:0] secs);
		int unsigned days_left;
		int unsigned tod;
		int unsigned yr;
		int unsigned ylen;
		int unsigned mon;
		int unsigned mlen;
		cal_date_t   d;
		days_left = secs / ucd_pkg::SecsPerDay;
		tod       = secs % ucd_pkg::SecsPerDay;
		yr        = ucd_pkg::EpochYear;
		ylen      = is_leap_year(yr) ? ucd_pkg::DaysLeap : ucd_pkg::DaysCommon;
		// A year is only taken off while the whole of it fits, so 31 December stays put.
		while (days_left >= ylen) begin
			days_left -= ylen;
			yr++;
			ylen = is_leap_year(yr) ? ucd_pkg::DaysLeap : ucd_pkg::DaysCommon;
		end
		mon  = 0;
		mlen = CommonMonthDays[0];
		while (mon < ucd_pkg::LastMonth && days_left >= mlen) begin
			days_left -= mlen;
			mon++;
			mlen = (mon == 1 && is_leap_year(yr)) ? LeapFebDays : CommonMonthDays[mon];
		end
		d.year   = 12'(yr);
		d.month  = 4'(mon + 1);
		d.day    = 5'(days_left + 1);
		d.hour   = 5'(tod / ucd_pkg::SecsPerHour);
		d.minute = 6'((tod % ucd_pkg::SecsPerHour) / ucd_pkg::SecsPerMin);
		d.second = 6'(tod % ucd_pkg::SecsPerMin);
		return d;
	endfunction

	// Random timestamps: plain 32-bit values, values at the edges of a day, and values on
	// the first, last and February days of a year.
	function automatic logic [31:0] random_timestamp();
		int unsigned       mode;
		int unsigned       yr;
		int unsigned       ylen;
		int unsigned       doy;
		int unsigned       sod;
		longint unsigned   days;
		longint unsigned   total;
		mode = $urandom_range(0, 9);
		if (mode < 4) begin
			return $urandom;
		end
		if (mode < 7) begin
			days = $urandom_range(0, LastFullDay);
			case ($urandom_range(0, 2))
				0:       sod = 0;
				1:       sod = ucd_pkg::SecsPerDay - 1;
				default: sod = $urandom_range(0, ucd_pkg::SecsPerDay - 1);
			endcase
			total = days * ucd_pkg::SecsPerDay + sod;
			return total[31:0];
		end
		yr   = $urandom_range(ucd_pkg::EpochYear, LastFullYear);
		days = 0;
		for (int unsigned y = ucd_pkg::EpochYear; y < yr; y++) begin
			days += is_leap_year(y) ? ucd_pkg::DaysLeap : ucd_pkg::DaysCommon;
		end
		ylen = is_leap_year(yr) ? ucd_pkg::DaysLeap : ucd_pkg::DaysCommon;
		case ($urandom_range(0, 4))
			0:       doy = 0;
			1:       doy = ylen - 1;
			2:       doy = 58;
			3:       doy = 59;
			default: doy = $urandom_range(0, ylen - 1);
		endcase
		total = (days + doy) * ucd_pkg::SecsPerDay +
			$urandom_range(0, ucd_pkg::SecsPerDay - 1);
		return total[31:0];
	endfunction

	function automatic void add_case(input logic [31:0] ts, input bit known,
			input int unsigned yr, input int unsigned mo, input int unsigned dy,
			input int unsigned hr, input int unsigned mi, input int unsigned se);
		date_case_t c;
		c.ts          = ts;
		c.known       = known;
		c.want.year   = 12'(yr);
		c.want.month  = 4'(mo);
		c.want.day    = 5'(dy);
		c.want.hour   = 5'(hr);
		c.want.minute = 6'(mi);
		c.want.second = 6'(se);
		directed_cases.push_back(c);
	endfunction

	// Holds valid low for the given number of cycles before the next transfer.
	task automatic sender_gap(input int unsigned cycles);
		if (cycles == 0) begin
			return;
		end
		@(negedge clk);
		ts_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic send_timestamp(input logic [31:0] ts, input cal_date_t want);
		@(negedge clk);
		ts_valid     <= 1'b1;
		unix_seconds <= ts;
		do @(posedge clk); while (!ts_ready);
		pending_dates.push_back(want);
	endtask

	task automatic drain_dates();
		@(negedge clk);
		ts_valid <= 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned ready_run;
		int unsigned stall_run;
		date_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet_tail) begin
				@(negedge clk);
				date_ready <= 1'b1;
			end else begin
				ready_run = $urandom_range(1, 48);
				stall_run = $urandom_range(1, 16);
				repeat (ready_run) begin
					@(negedge clk);
					date_ready <= 1'b1;
				end
				// A stall burst is cut short once the final stretch of the run begins.
				repeat (stall_run) begin
					@(negedge clk);
					date_ready <= quiet_tail;
				end
			end
		end
	end

	always @(posedge clk) begin : date_check
		cal_date_t want;
		if (arst_n && date_valid && date_ready) begin
			if (pending_dates.size() == 0) begin
				$error("date transfer with no timestamp outstanding");
				mismatch_count++;
			end else begin
				want = pending_dates.pop_front();
				if (year !== want.year) begin
					$error("year: expected %0d, actual %0d", want.year, year);
					mismatch_count++;
				end
				if (month !== want.month) begin
					$error("month: expected %0d, actual %0d", want.month, month);
					mismatch_count++;
				end
				if (day !== want.day) begin
					$error("day: expected %0d, actual %0d", want.day, day);
					mismatch_count++;
				end
				if (hour !== want.hour) begin
					$error("hour: expected %0d, actual %0d", want.hour, hour);
					mismatch_count++;
				end
				if (minute !== want.minute) begin
					$error("minute: expected %0d, actual %0d", want.minute, minute);
					mismatch_count++;
				end
				if (second !== want.second) begin
					$error("second: expected %0d, actual %0d", want.second, second);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		logic [31:0] ts;
		ts_valid     = 1'b0;
		unix_seconds = '0;

		add_case(32'd0,          1'b1, 1970, 1, 1, 0, 0, 0);
		add_case(32'hFFFF_FFFF,  1'b1, 2106, 2, 7, 6, 28, 15);
		add_case(32'd86399,      1'b1, 1970, 1, 1, 23, 59, 59);
		add_case(32'd86400,      1'b0, 0, 0, 0, 0, 0, 0);
		add_case(32'd45296,      1'b0, 0, 0, 0, 0, 0, 0);
		add_case(32'd31535999,   1'b0, 0, 0, 0, 0, 0, 0);
		add_case(32'd31536000,   1'b0, 0, 0, 0, 0, 0, 0);
		add_case(32'd68169600,   1'b0, 0, 0, 0, 0, 0, 0);
		// The last day of a leap year, at its first and last second, then the day after.
		add_case(32'd94608000,   1'b0, 0, 0, 0, 0, 0, 0);
		add_case(32'd94694399,   1'b0, 0, 0, 0, 0, 0, 0);
		add_case(32'd94694400,   1'b0, 0, 0, 0, 0, 0, 0);
		add_case(32'd951782400,  1'b0, 0, 0, 0, 0, 0, 0);
		add_case(32'd978220800,  1'b0, 0, 0, 0, 0, 0, 0);
		add_case(32'd2147483647, 1'b0, 0, 0, 0, 0, 0, 0);
		add_case(32'd2147483648, 1'b0, 0, 0, 0, 0, 0, 0);
		// 2100 is not a leap year, so February ends on the 28th.
		add_case(32'd4107456000, 1'b0, 0, 0, 0, 0, 0, 0);
		add_case(32'd4107542400, 1'b0, 0, 0, 0, 0, 0, 0);
		add_case(32'd4291747200, 1'b0, 0, 0, 0, 0, 0, 0);
		add_case(32'hAAAA_AAAA,  1'b0, 0, 0, 0, 0, 0, 0);
		add_case(32'h5555_5555,  1'b0, 0, 0, 0, 0, 0, 0);

		@(posedge arst_n);
		foreach (directed_cases[i]) begin
			if ($urandom_range(0, 2) == 0) begin
				sender_gap($urandom_range(1, 16));
			end
			send_timestamp(directed_cases[i].ts, directed_cases[i].known ?
				directed_cases[i].want : date_from_seconds(directed_cases[i].ts));
		end
		drain_dates();

		for (int unsigned n = 0; n < RandomItems; n++) begin
			if (n == RandomItems / 2) begin
				drain_dates();
			end
			if (n >= RandomItems - QuietItems) begin
				quiet_tail = 1'b1;
			end
			// Runs of back-to-back transfers are left between the random gaps.
			if (!quiet_tail && (n % 64) < 40 && $urandom_range(0, 2) == 0) begin
				sender_gap($urandom_range(1, 16));
			end
			ts = random_timestamp();
			send_timestamp(ts, date_from_seconds(ts));
		end
		drain_dates();
		repeat (TailCycles) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ unix_seconds_to_calendar_date.f @@
src/ucd_pkg.sv
src/ucd_datapath.sv
src/ucd_controller.sv
src/unix_seconds_to_calendar_date.sv
tb/unix_seconds_to_calendar_date_tb.sv
